FILE: rtl/core/cpdd_pkg.sv
// ----------------------------------------------------------------------------
// cpdd_pkg
// Shared types and constants for the cascaded PID differential-drive block:
// request and result payloads, configuration set, microcode word fields.
// ----------------------------------------------------------------------------
package cpdd_pkg;

  // Fixed-point format of the yaw-rate loop and width of the drive commands
  localparam int RATE_F   = 12;
  localparam int DRIVE_W  = 16;

  // Gyro count to rad/s, Q24: round(250 * 3.14159 / 180 * 2^24)
  localparam longint GYRO_K     = 73204353;
  localparam int     GYRO_SHIFT = 39 - RATE_F;
  localparam int     LINE_SHIFT = 16 - RATE_F;

  // Widths of the loop state (signed)
  localparam longint RATE_MAX = (GYRO_K * 32768) >> GYRO_SHIFT;
  localparam int     RATE_W   = $clog2(RATE_MAX + 1) + 1;
  localparam int     SETPT_W  = 16;
  localparam int     ERR_W    = ((RATE_W > SETPT_W) ? RATE_W : SETPT_W) + 1;
  localparam int     RINT_W   = 18;
  localparam int     LINT_W   = 13;

  // Drive saturation bounds
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Request and result payloads
  typedef struct packed {
    logic               req_type;
    logic signed [15:0] gyro_raw;
    logic [9:0]         line_position;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [9:0]  rate_kp;
    logic [7:0]  rate_ki;
    logic [7:0]  rate_kd;
    logic [16:0] rate_integral_limit;
    logic [15:0] line_kp;
    logic [15:0] line_ki;
    logic [11:0] line_integral_limit;
    logic [9:0]  line_target;
  } cfg_t;

  // Microcode word fields
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GYRO,
    MUL_RKP,
    MUL_RKI,
    MUL_RKD,
    MUL_LKP,
    MUL_LKI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_TRUNC_GYRO,
    ACC_TRUNC_RATE,
    ACC_TRUNC_LINE
  } acc_op_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_RATE_ERR,
    DP_RATE_INT,
    DP_PREV,
    DP_LINE_ERR,
    DP_LINE_INT,
    DP_SETPT,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BR_CAM,
    SEQ_END
  } seq_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    dp_op_t   dp_op;
    seq_op_t  seq_op;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic is_cam;
    logic out_blocked;
  } dp_stat_t;

endpackage

FILE: rtl/core/cascaded_pid_diff_drive.sv
// ----------------------------------------------------------------------------
// cascaded_pid_diff_drive
// Cascaded line/yaw-rate PI(D) steering for a differential-drive robot.
//
// Requests enter on in_valid/in_ready as in_data. A camera request
// (req_type 1) updates the line integral and the yaw-rate setpoint and
// gives no result. A gyro request (req_type 0) runs the yaw-rate PID and
// gives one result on out_valid/out_ready: right = +turn, left = -turn.
// Gains, limits and the line target sit in the APB register file; write
// them only while the block is idle.
// One request is in flight at a time. A gyro request takes 9 microcode
// steps and a camera request 7; in_ready returns once the last step has
// executed, in the same cycle as a gyro result becomes valid. The step
// count is set by the single shared multiplier and accumulator the
// microprogram walks through.
// The result sits in an output register; a new request is taken while it
// waits. If it is still held when the next result is due, the emit step
// stalls until out_ready. Reset (rst_n low) loads the register defaults,
// clears the loop state and leaves the block idle and ready.
// ----------------------------------------------------------------------------
module cascaded_pid_diff_drive
  import cpdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  ucode_t   uc;
  dp_stat_t stat;
  logic     busy;
  logic     step_en;
  logic     start;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  cpdd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpdd_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .stat    (stat),
    .busy    (busy),
    .step_en (step_en),
    .uc      (uc)
  );

  cpdd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .load_en   (start),
    .in_item   (in_data),
    .step_en   (step_en),
    .uc        (uc),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_data),
    .stat      (stat)
  );

  // A result appears only from an executed emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step_en && uc.dp_op == DP_EMIT))
    else $error("result valid rose without an emit step");

  // A blocked emit holds the sequencer on the same step
  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && uc.dp_op == DP_EMIT && stat.out_blocked) |=> $stable(uc))
    else $error("sequencer moved past a blocked emit step");

  // Left drive mirrors right drive, up to saturation at the ends
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.left_drive == DRIVE_W'(-out_data.right_drive)) ||
      (out_data.right_drive == DRIVE_MIN && out_data.left_drive == DRIVE_MAX) ||
      (out_data.right_drive == DRIVE_MAX && out_data.left_drive == DRIVE_MIN))
    else $error("left and right drives are not mirrored");

endmodule

FILE: rtl/core/cpdd_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpdd_cfg_regs
// APB-style register file holding the loop gains, limits and line target.
// ----------------------------------------------------------------------------
module cpdd_cfg_regs
  import cpdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  typedef enum logic [2:0] {
    REG_RATE_KP,
    REG_RATE_KI,
    REG_RATE_KD,
    REG_RATE_ILIM,
    REG_LINE_KP,
    REG_LINE_KI,
    REG_LINE_ILIM,
    REG_LINE_TARGET
  } reg_idx_t;

  localparam cfg_t CFG_RESET = '{
    rate_kp:             10'd350,
    rate_ki:             8'd15,
    rate_kd:             8'd0,
    rate_integral_limit: 17'd40960,
    line_kp:             16'd328,
    line_ki:             16'd0,
    line_integral_limit: 12'd1000,
    line_target:         10'd240
  };

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write, upper bits beyond each field dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_RATE_KP:     cfg_nxt.rate_kp             = pwdata[9:0];
        REG_RATE_KI:     cfg_nxt.rate_ki             = pwdata[7:0];
        REG_RATE_KD:     cfg_nxt.rate_kd             = pwdata[7:0];
        REG_RATE_ILIM:   cfg_nxt.rate_integral_limit = pwdata[16:0];
        REG_LINE_KP:     cfg_nxt.line_kp             = pwdata[15:0];
        REG_LINE_KI:     cfg_nxt.line_ki             = pwdata[15:0];
        REG_LINE_ILIM:   cfg_nxt.line_integral_limit = pwdata[11:0];
        REG_LINE_TARGET: cfg_nxt.line_target         = pwdata[9:0];
        default:         cfg_nxt                     = cfg_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_RATE_KP:     prdata = CFG_DATA_W'(cfg_r.rate_kp);
      REG_RATE_KI:     prdata = CFG_DATA_W'(cfg_r.rate_ki);
      REG_RATE_KD:     prdata = CFG_DATA_W'(cfg_r.rate_kd);
      REG_RATE_ILIM:   prdata = CFG_DATA_W'(cfg_r.rate_integral_limit);
      REG_LINE_KP:     prdata = CFG_DATA_W'(cfg_r.line_kp);
      REG_LINE_KI:     prdata = CFG_DATA_W'(cfg_r.line_ki);
      REG_LINE_ILIM:   prdata = CFG_DATA_W'(cfg_r.line_integral_limit);
      REG_LINE_TARGET: prdata = CFG_DATA_W'(cfg_r.line_target);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/cpdd_sequencer.sv
// ----------------------------------------------------------------------------
// cpdd_sequencer
// Microprogram ROM and step counter. One control word per step; step 0
// branches to the camera routine, the last step of each routine ends it.
// ----------------------------------------------------------------------------
module cpdd_sequencer
  import cpdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output logic     step_en,
  output ucode_t   uc
);

  localparam int UPC_W     = 4;
  localparam int ROM_DEPTH = 1 << UPC_W;
  localparam logic [UPC_W-1:0] CAM_ENTRY = UPC_W'(9);

  // Gyro routine at 0..8, camera routine at 9..14
  localparam ucode_t ROM [ROM_DEPTH] = '{
    '{MUL_GYRO, ACC_HOLD,       DP_NOP,      SEQ_BR_CAM},  // 0  rate product
    '{MUL_NONE, ACC_TRUNC_GYRO, DP_NOP,      SEQ_NEXT},    // 1  scale to Q(F)
    '{MUL_NONE, ACC_HOLD,       DP_RATE_ERR, SEQ_NEXT},    // 2  error
    '{MUL_RKP,  ACC_HOLD,       DP_RATE_INT, SEQ_NEXT},    // 3  kp*e, integral
    '{MUL_RKI,  ACC_LOAD,       DP_NOP,      SEQ_NEXT},    // 4  ki*I
    '{MUL_RKD,  ACC_ADD,        DP_PREV,     SEQ_NEXT},    // 5  kd*(e-prev)
    '{MUL_NONE, ACC_ADD,        DP_NOP,      SEQ_NEXT},    // 6
    '{MUL_NONE, ACC_TRUNC_RATE, DP_NOP,      SEQ_NEXT},    // 7  drop Q(F)
    '{MUL_NONE, ACC_HOLD,       DP_EMIT,     SEQ_END},     // 8  drives out
    '{MUL_NONE, ACC_HOLD,       DP_LINE_ERR, SEQ_NEXT},    // 9  line error
    '{MUL_LKP,  ACC_HOLD,       DP_LINE_INT, SEQ_NEXT},    // 10 kp*e, integral
    '{MUL_LKI,  ACC_LOAD,       DP_NOP,      SEQ_NEXT},    // 11 ki*I
    '{MUL_NONE, ACC_ADD,        DP_NOP,      SEQ_NEXT},    // 12
    '{MUL_NONE, ACC_TRUNC_LINE, DP_NOP,      SEQ_NEXT},    // 13 Q16 to Q(F)
    '{MUL_NONE, ACC_HOLD,       DP_SETPT,    SEQ_END},     // 14 store setpoint
    '{MUL_NONE, ACC_HOLD,       DP_NOP,      SEQ_END}      // 15 spare
  };

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             stall;

  assign uc      = ROM[upc_r];
  // Emit waits while the result register is still held
  assign stall   = (uc.dp_op == DP_EMIT) && stat.out_blocked;
  assign step_en = busy_r && !stall;
  assign busy    = busy_r;

  // Step counter and branch
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = '0;
    end else if (step_en) begin
      unique case (uc.seq_op)
        SEQ_END:    busy_nxt = 1'b0;
        SEQ_BR_CAM: upc_nxt  = stat.is_cam ? CAM_ENTRY : upc_r + 1'b1;
        default:    upc_nxt  = upc_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

FILE: rtl/core/cpdd_datapath.sv
// ----------------------------------------------------------------------------
// cpdd_datapath
// Shared multiplier, accumulator and loop state driven by the microcode
// word, plus the request register and the result register.
// ----------------------------------------------------------------------------
module cpdd_datapath
  import cpdd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      load_en,
  input  in_item_t  in_item,
  input  logic      step_en,
  input  ucode_t    uc,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output dp_stat_t  stat
);

  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = ((ERR_W + 1) > RINT_W) ? (ERR_W + 1) : RINT_W;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  localparam int RSUM_W  = ((RINT_W > ERR_W) ? RINT_W : ERR_W) + 1;
  localparam int LSUM_W  = LINT_W + 1;

  localparam logic signed [MUL_A_W-1:0] GYRO_K_S = MUL_A_W'(GYRO_K);

  // Rounding biases that turn the arithmetic shift into truncation to zero
  localparam logic signed [ACC_W-1:0] BIAS_GYRO = ACC_W'((64'd1 << GYRO_SHIFT) - 64'd1);
  localparam logic signed [ACC_W-1:0] BIAS_RATE = ACC_W'((64'd1 << RATE_F) - 64'd1);
  localparam logic signed [ACC_W-1:0] BIAS_LINE = ACC_W'((64'd1 << LINE_SHIFT) - 64'd1);

  localparam logic signed [SETPT_W-1:0] SP_MAX = {1'b0, {(SETPT_W-1){1'b1}}};
  localparam logic signed [SETPT_W-1:0] SP_MIN = {1'b1, {(SETPT_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]   SP_HI  = ACC_W'(SP_MAX);
  localparam logic signed [ACC_W-1:0]   SP_LO  = ACC_W'(SP_MIN);
  localparam logic signed [ACC_W-1:0]   DRV_HI = ACC_W'(DRIVE_MAX);
  localparam logic signed [ACC_W-1:0]   DRV_LO = ACC_W'(DRIVE_MIN);

  function automatic logic signed [DRIVE_W-1:0] sat_drive(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [DRIVE_W-1:0] r;
    if (v > DRV_HI) begin
      r = DRIVE_MAX;
    end else if (v < DRV_LO) begin
      r = DRIVE_MIN;
    end else begin
      r = DRIVE_W'(v);
    end
    return r;
  endfunction

  // Request register and payload registers
  in_item_t                   item_r, item_nxt;
  logic signed [ACC_W-1:0]    prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ERR_W-1:0]    err_r, err_nxt;
  out_item_t                  out_item_r, out_item_nxt;

  // Loop state
  logic signed [SETPT_W-1:0]  rate_setpoint_r, rate_setpoint_nxt;
  logic signed [RINT_W-1:0]   rate_integral_r, rate_integral_nxt;
  logic signed [ERR_W-1:0]    rate_prev_error_r, rate_prev_error_nxt;
  logic signed [LINT_W-1:0]   line_integral_r, line_integral_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ERR_W:0]      rate_diff;
  logic signed [ACC_W-1:0]    trunc_in, trunc_bias, trunc_sum, neg_acc;
  logic signed [RSUM_W-1:0]   rsum, rlim;
  logic signed [LSUM_W-1:0]   lsum, llim;
  logic signed [10:0]         line_err;

  assign out_valid        = out_valid_r;
  assign out_item         = out_item_r;
  assign stat.is_cam      = item_r.req_type;
  assign stat.out_blocked = out_valid_r && !out_ready;

  assign item_nxt  = load_en ? in_item : item_r;
  assign rate_diff = (ERR_W+1)'(err_r) - (ERR_W+1)'(rate_prev_error_r);
  assign line_err  = $signed({1'b0, cfg.line_target}) - $signed({1'b0, item_r.line_position});
  assign neg_acc   = -acc_r;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uc.mul_sel)
      MUL_GYRO: begin
        mul_a = GYRO_K_S;
        mul_b = MUL_B_W'(item_r.gyro_raw);
      end
      MUL_RKP: begin
        mul_a = MUL_A_W'(cfg.rate_kp);
        mul_b = MUL_B_W'(err_r);
      end
      MUL_RKI: begin
        mul_a = MUL_A_W'(cfg.rate_ki);
        mul_b = MUL_B_W'(rate_integral_r);
      end
      MUL_RKD: begin
        mul_a = MUL_A_W'(cfg.rate_kd);
        mul_b = MUL_B_W'(rate_diff);
      end
      MUL_LKP: begin
        mul_a = MUL_A_W'(cfg.line_kp);
        mul_b = MUL_B_W'(err_r);
      end
      MUL_LKI: begin
        mul_a = MUL_A_W'(cfg.line_ki);
        mul_b = MUL_B_W'(line_integral_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Truncating shift source and bias
  always_comb begin
    trunc_in   = acc_r;
    trunc_bias = '0;
    case (uc.acc_op)
      ACC_TRUNC_GYRO: begin
        trunc_in = prod_r;
        if (prod_r[ACC_W-1]) trunc_bias = BIAS_GYRO;
      end
      ACC_TRUNC_RATE: if (acc_r[ACC_W-1]) trunc_bias = BIAS_RATE;
      ACC_TRUNC_LINE: if (acc_r[ACC_W-1]) trunc_bias = BIAS_LINE;
      default:        trunc_bias = '0;
    endcase
  end
  assign trunc_sum = trunc_in + trunc_bias;

  // Integral sums and clamp limits
  assign rsum = RSUM_W'(rate_integral_r) + RSUM_W'(err_r);
  assign rlim = RSUM_W'(cfg.rate_integral_limit);
  assign lsum = LSUM_W'(line_integral_r) + LSUM_W'(err_r);
  assign llim = LSUM_W'(cfg.line_integral_limit);

  // Step execution
  always_comb begin
    prod_nxt            = prod_r;
    acc_nxt             = acc_r;
    err_nxt             = err_r;
    rate_setpoint_nxt   = rate_setpoint_r;
    rate_integral_nxt   = rate_integral_r;
    rate_prev_error_nxt = rate_prev_error_r;
    line_integral_nxt   = line_integral_r;
    out_item_nxt        = out_item_r;
    out_valid_nxt       = out_valid_r && !out_ready;

    if (step_en) begin
      if (uc.mul_sel != MUL_NONE) prod_nxt = mul_a * mul_b;

      case (uc.acc_op)
        ACC_LOAD:       acc_nxt = prod_r;
        ACC_ADD:        acc_nxt = acc_r + prod_r;
        ACC_TRUNC_GYRO: acc_nxt = trunc_sum >>> GYRO_SHIFT;
        ACC_TRUNC_RATE: acc_nxt = trunc_sum >>> RATE_F;
        ACC_TRUNC_LINE: acc_nxt = trunc_sum >>> LINE_SHIFT;
        default:        acc_nxt = acc_r;
      endcase

      unique case (uc.dp_op)
        DP_RATE_ERR: err_nxt = ERR_W'(rate_setpoint_r) - ERR_W'(acc_r);
        DP_RATE_INT: begin
          if (rsum > rlim) begin
            rate_integral_nxt = RINT_W'(rlim);
          end else if (rsum < -rlim) begin
            rate_integral_nxt = RINT_W'(-rlim);
          end else begin
            rate_integral_nxt = RINT_W'(rsum);
          end
        end
        DP_PREV:     rate_prev_error_nxt = err_r;
        DP_LINE_ERR: err_nxt = ERR_W'(line_err);
        DP_LINE_INT: begin
          if (lsum > llim) begin
            line_integral_nxt = LINT_W'(llim);
          end else if (lsum < -llim) begin
            line_integral_nxt = LINT_W'(-llim);
          end else begin
            line_integral_nxt = LINT_W'(lsum);
          end
        end
        DP_SETPT: begin
          if (acc_r > SP_HI) begin
            rate_setpoint_nxt = SP_MAX;
          end else if (acc_r < SP_LO) begin
            rate_setpoint_nxt = SP_MIN;
          end else begin
            rate_setpoint_nxt = SETPT_W'(acc_r);
          end
        end
        DP_EMIT: begin
          out_item_nxt.right_drive = sat_drive(acc_r);
          out_item_nxt.left_drive  = sat_drive(neg_acc);
          out_valid_nxt            = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      rate_setpoint_r   <= '0;
      rate_integral_r   <= '0;
      rate_prev_error_r <= '0;
      line_integral_r   <= '0;
    end else begin
      out_valid_r       <= out_valid_nxt;
      rate_setpoint_r   <= rate_setpoint_nxt;
      rate_integral_r   <= rate_integral_nxt;
      rate_prev_error_r <= rate_prev_error_nxt;
      line_integral_r   <= line_integral_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
